// ===== hdl/csv_pkg.sv =====
// Shared types and constants for the cosine similarity core.
package csv_pkg;
  localparam int MaxElementsDefault = 1024;
  localparam int AccW = 48;
  localparam int QueueDepth = 2;

  typedef struct packed {
    logic signed [AccW-1:0] dot;
    logic [AccW-1:0] sx;
    logic [AccW-1:0] sy;
  } sums_t;
endpackage

// ===== hdl/cosine_similarity_vectors_core.sv =====
// Top level of the streaming cosine similarity core.
// Throughput: one element pair per cycle while s_tready is high; the back end takes one vector at a time.
// The last pair's sums pass the product and sums registers and the queue to the back end,
// which runs 3 product steps, then 16 search bits; a zero norm or +/-1 ends it early.
// Sums register and two-entry queue let later vectors accumulate; then input stalls.
// Reset (rst, synchronous) clears accumulators, queue and back-end state.
module cosine_similarity_vectors_core #(
  parameter int MAX_ELEMENTS = csv_pkg::MaxElementsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [31:0] s_tdata, // x_value[15:0], y_value[31:16]
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  output logic [15:0] m_tdata, // similarity[15:0]
  output logic m_tuser         // zero_norm
);
  logic f_valid, f_ready, q_valid, q_ready, take;
  csv_pkg::sums_t f_sums, q_sums;

  // Front stalls only when a last pair meets a sums register the queue cannot take.
  assign take = s_tvalid && s_tready;

  csv_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
    .clk, .rst, .x_value(s_tdata[15:0]), .y_value(s_tdata[31:16]),
    .last(s_tlast), .take, .in_ready(s_tready), .sums_valid(f_valid), .sums(f_sums),
    .sums_ready(f_ready));

  csv_queue u_queue (.clk, .rst, .in_valid(f_valid), .in_data(f_sums),
    .in_ready(f_ready), .out_valid(q_valid), .out_data(q_sums),
    .out_ready(q_ready));

  csv_back u_back (.clk, .rst, .in_valid(q_valid), .in_data(q_sums),
    .in_ready(q_ready), .out_valid(m_tvalid), .similarity(m_tdata),
    .zero_norm(m_tuser), .out_ready(m_tready));
endmodule

// ===== hdl/csv_front.sv =====
// Front end: multiply and saturating accumulation of element pairs.
module csv_front #(
  parameter int MAX_ELEMENTS = csv_pkg::MaxElementsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic signed [15:0] x_value,
  input  logic signed [15:0] y_value,
  input  logic last,
  input  logic take,
  output logic in_ready,
  output logic sums_valid,
  output csv_pkg::sums_t sums,
  input  logic sums_ready
);
  localparam logic signed [csv_pkg::AccW-1:0] Bound =
    csv_pkg::AccW'(64'(MAX_ELEMENTS) << 30);

  logic signed [31:0] pxy, pxx, pyy;
  logic signed [csv_pkg::AccW-1:0] dot, sx, sy;
  logic p_valid, p_last;
  logic signed [csv_pkg::AccW-1:0] dot_next, sx_next, sy_next;
  logic stall, sums_valid_next;

  function automatic logic signed [csv_pkg::AccW-1:0] sat(
    input logic signed [csv_pkg::AccW-1:0] a, input logic signed [31:0] p);
    logic signed [csv_pkg::AccW:0] s;
    begin
      s = {a[csv_pkg::AccW-1], a} + (csv_pkg::AccW+1)'(p);
      if (s > (csv_pkg::AccW+1)'(Bound)) sat = Bound;
      else if (s < -(csv_pkg::AccW+1)'(Bound)) sat = -Bound;
      else sat = s[csv_pkg::AccW-1:0];
    end
  endfunction

  assign dot_next = sat(dot, pxy);
  assign sx_next = sat(sx, pxx);
  assign sy_next = sat(sy, pyy);

  // a last pair waits while the sums register still holds an untaken transfer
  assign stall = p_valid && p_last && sums_valid && !sums_ready;
  assign in_ready = !stall;
  assign sums_valid_next = (p_valid && p_last && !stall) || (sums_valid && !sums_ready);

  always_ff @(posedge clk) begin
    if (take) begin
      pxy <= x_value * y_value;
      pxx <= x_value * x_value;
      pyy <= y_value * y_value;
      p_last <= last;
    end
    if (rst) begin
      p_valid <= 1'b0;
      dot <= '0;
      sx <= '0;
      sy <= '0;
      sums_valid <= 1'b0;
    end else begin
      sums_valid <= sums_valid_next;
      if (!stall) begin
        p_valid <= take;
        if (p_valid) begin
          if (p_last) begin
            sums <= '{dot: dot_next, sx: sx_next, sy: sy_next};
            dot <= '0;
            sx <= '0;
            sy <= '0;
          end else begin
            dot <= dot_next;
            sx <= sx_next;
            sy <= sy_next;
          end
        end
      end
    end
  end
endmodule

// ===== hdl/csv_queue.sv =====
// Short FIFO of finished sums between front and back.
module csv_queue (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  csv_pkg::sums_t in_data,
  output logic in_ready,
  output logic out_valid,
  output csv_pkg::sums_t out_data,
  input  logic out_ready
);
  // pointers wrap naturally, so the depth is a power of two
  localparam int PtrW = $clog2(csv_pkg::QueueDepth);
  localparam int CntW = $clog2(csv_pkg::QueueDepth + 1);
  localparam logic [CntW-1:0] Full = CntW'(csv_pkg::QueueDepth);

  csv_pkg::sums_t mem [csv_pkg::QueueDepth];
  logic [PtrW-1:0] wp, rp;
  logic [CntW-1:0] cnt;
  logic push, pop;

  assign in_ready = cnt != Full;
  assign out_valid = cnt != '0;
  assign out_data = mem[rp];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_data;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + CntW'(push) - CntW'(pop);
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst) cnt <= Full)
    else $error("queue count overflow");
  a_push: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> cnt == $past(cnt) + 1'b1) else $error("push lost");
  a_pop: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> cnt == $past(cnt) - 1'b1) else $error("pop lost");
endmodule

// ===== hdl/csv_back.sv =====
// Back end: exact rounded cosine via bit-serial binary search.
module csv_back (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  csv_pkg::sums_t in_data,
  output logic in_ready,
  output logic out_valid,
  output logic [15:0] similarity,
  output logic zero_norm,
  input  logic out_ready
);
  localparam logic [2:0] SIdle = 3'd0, SPm = 3'd1, SBit = 3'd2, SMul = 3'd3,
    SCmp = 3'd4, SOut = 3'd5;

  logic [2:0] state;
  logic neg;
  logic [47:0] ad, sx, sy;
  logic [95:0] p;
  logic [127:0] rhs;
  logic [15:0] r;
  logic [4:0] bitn;
  logic [16:0] cand;
  logic [31:0] k;
  logic [129:0] lhs;
  logic [2:0] mstep;
  logic [63:0] pa;

  // candidate r | bit, odd = 2*cand-1
  logic [16:0] try_r;
  assign try_r = {1'b0, r} | (17'd1 << bitn);

  // one 32-bit slice of sx*sy times the squared odd candidate
  assign pa = p[mstep[1:0]*32 +: 32] * k;

  assign in_ready = state == SIdle;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        SIdle: if (in_valid) begin
          neg <= in_data.dot[47];
          ad <= in_data.dot[47] ? 48'(-in_data.dot) : in_data.dot;
          sx <= in_data.sx;
          sy <= in_data.sy;
          if (in_data.sx == '0 || in_data.sy == '0) begin
            similarity <= '0;
            zero_norm <= 1'b1;
            out_valid <= 1'b1;
            state <= SOut;
          end else begin
            zero_norm <= 1'b0;
            p <= '0;
            mstep <= '0;
            state <= SPm;
          end
        end
        SPm: begin
          // sx*sy and ad^2 over 3 steps of 16-bit slices
          p <= p + (96'(sx * sy[mstep[1:0]*16 +: 16]) << (mstep[1:0]*16));
          rhs <= (mstep == 3'd0 ? '0 : rhs) +
            (128'(ad * ad[mstep[1:0]*16 +: 16]) << (mstep[1:0]*16 + 32));
          mstep <= mstep + 3'd1;
          if (mstep == 3'd2) begin
            r <= '0;
            bitn <= 5'd15;
            state <= SBit;
          end
        end
        SBit: begin
          cand <= try_r;
          k <= 32'(({try_r, 1'b0} - 18'd1)) * 32'(({try_r, 1'b0} - 18'd1));
          lhs <= '0;
          mstep <= '0;
          state <= SMul;
        end
        SMul: begin
          lhs <= lhs + (130'(pa) << (mstep[1:0] * 32));
          mstep <= mstep + 3'd1;
          if (mstep == 3'd2) state <= SCmp;
        end
        SCmp: begin
          if (cand <= 17'd32768 && lhs <= {2'b0, rhs}) r <= cand[15:0] | r;
          if (cand <= 17'd32768 && lhs <= {2'b0, rhs} && cand[15]) begin
            r <= neg ? 16'h8000 : 16'h7fff;
            similarity <= neg ? 16'h8000 : 16'h7fff;
            out_valid <= 1'b1;
            state <= SOut;
          end else if (bitn == 5'd0) begin
            similarity <= neg ? 16'(-((cand <= 17'd32768 && lhs <= {2'b0, rhs}) ?
              cand[15:0] | r : r)) : ((cand <= 17'd32768 && lhs <= {2'b0, rhs}) ?
              cand[15:0] | r : r);
            out_valid <= 1'b1;
            state <= SOut;
          end else begin
            bitn <= bitn - 5'd1;
            state <= SBit;
          end
        end
        SOut: if (out_ready) begin
          out_valid <= 1'b0;
          state <= SIdle;
        end
        default: state <= SIdle;
      endcase
    end
  end

  a_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == SOut) else $error("result outside output state");
  a_zn: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_norm |-> similarity == '0) else $error("zero norm value");
endmodule
